// File: rtl/cp2u8_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cp2u8_pkg
// Codepage tables, lead-byte constants and encoding types for the
// codepage to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package cp2u8_pkg;

    typedef logic [1:0]  t_codepage;
    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_codepoint;

    // codepage_select codes
    localparam t_codepage CP_1252 = 2'd0;
    localparam t_codepage CP_1250 = 2'd1;
    localparam t_codepage CP_1251 = 2'd2;
    localparam t_codepage CP_PASS = 2'd3;

    // Table RAM: {codepage, slot} addressing, first three pages loaded
    localparam int TBL_AW     = 9;
    localparam int TBL_DEPTH  = 512;
    localparam int TBL_WIDTH  = 16;
    localparam logic [TBL_AW-1:0] TBL_FILL_LAST = 9'd383;

    localparam t_codepoint CP_REPLACEMENT = 16'hFFFD;
    localparam t_codepoint CP_TWO_LIMIT   = 16'h0800;
    localparam logic [2:0] LEAD2_TAG      = 3'b110;
    localparam logic [3:0] LEAD3_TAG      = 4'b1110;
    localparam logic [1:0] CONT_TAG       = 2'b10;

    localparam t_codepoint MAP_1252 [128] = '{
        16'h20AC, 16'h0000, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h0000, 16'h017D, 16'h0000,
        16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h0000, 16'h017E, 16'h0178,
        16'h00A0, 16'h00A1, 16'h00A2, 16'h00A3, 16'h00A4, 16'h00A5, 16'h00A6, 16'h00A7,
        16'h00A8, 16'h00A9, 16'h00AA, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h00AF,
        16'h00B0, 16'h00B1, 16'h00B2, 16'h00B3, 16'h00B4, 16'h00B5, 16'h00B6, 16'h00B7,
        16'h00B8, 16'h00B9, 16'h00BA, 16'h00BB, 16'h00BC, 16'h00BD, 16'h00BE, 16'h00BF,
        16'h00C0, 16'h00C1, 16'h00C2, 16'h00C3, 16'h00C4, 16'h00C5, 16'h00C6, 16'h00C7,
        16'h00C8, 16'h00C9, 16'h00CA, 16'h00CB, 16'h00CC, 16'h00CD, 16'h00CE, 16'h00CF,
        16'h00D0, 16'h00D1, 16'h00D2, 16'h00D3, 16'h00D4, 16'h00D5, 16'h00D6, 16'h00D7,
        16'h00D8, 16'h00D9, 16'h00DA, 16'h00DB, 16'h00DC, 16'h00DD, 16'h00DE, 16'h00DF,
        16'h00E0, 16'h00E1, 16'h00E2, 16'h00E3, 16'h00E4, 16'h00E5, 16'h00E6, 16'h00E7,
        16'h00E8, 16'h00E9, 16'h00EA, 16'h00EB, 16'h00EC, 16'h00ED, 16'h00EE, 16'h00EF,
        16'h00F0, 16'h00F1, 16'h00F2, 16'h00F3, 16'h00F4, 16'h00F5, 16'h00F6, 16'h00F7,
        16'h00F8, 16'h00F9, 16'h00FA, 16'h00FB, 16'h00FC, 16'h00FD, 16'h00FE, 16'h00FF
    };

    localparam t_codepoint MAP_1250 [128] = '{
        16'h20AC, 16'h0000, 16'h201A, 16'h0000, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h0000, 16'h2030, 16'h0160, 16'h2039, 16'h015A, 16'h0164, 16'h017D, 16'h0179,
        16'h0000, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h0000, 16'h2122, 16'h0161, 16'h203A, 16'h015B, 16'h0165, 16'h017E, 16'h017A,
        16'h00A0, 16'h02C7, 16'h02D8, 16'h0141, 16'h00A4, 16'h0104, 16'h00A6, 16'h00A7,
        16'h00A8, 16'h00A9, 16'h015E, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h017B,
        16'h00B0, 16'h00B1, 16'h02DB, 16'h0142, 16'h00B4, 16'h00B5, 16'h00B6, 16'h00B7,
        16'h00B8, 16'h0105, 16'h015F, 16'h00BB, 16'h013D, 16'h02DD, 16'h013E, 16'h017C,
        16'h0154, 16'h00C1, 16'h00C2, 16'h0102, 16'h00C4, 16'h0139, 16'h0106, 16'h00C7,
        16'h010C, 16'h00C9, 16'h0118, 16'h00CB, 16'h011A, 16'h00CD, 16'h00CE, 16'h010E,
        16'h0110, 16'h0143, 16'h0147, 16'h00D3, 16'h00D4, 16'h0150, 16'h00D6, 16'h00D7,
        16'h0158, 16'h016E, 16'h00DA, 16'h0170, 16'h00DC, 16'h00DD, 16'h0162, 16'h00DF,
        16'h0155, 16'h00E1, 16'h00E2, 16'h0103, 16'h00E4, 16'h013A, 16'h0107, 16'h00E7,
        16'h010D, 16'h00E9, 16'h0119, 16'h00EB, 16'h011B, 16'h00ED, 16'h00EE, 16'h010F,
        16'h0111, 16'h0144, 16'h0148, 16'h00F3, 16'h00F4, 16'h0151, 16'h00F6, 16'h00F7,
        16'h0159, 16'h016F, 16'h00FA, 16'h0171, 16'h00FC, 16'h00FD, 16'h0163, 16'h02D9
    };

    localparam t_codepoint MAP_1251 [128] = '{
        16'h0402, 16'h0403, 16'h201A, 16'h0453, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
        16'h20AC, 16'h2030, 16'h0409, 16'h2039, 16'h040A, 16'h040C, 16'h040B, 16'h040F,
        16'h0452, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
        16'h0000, 16'h2122, 16'h0459, 16'h203A, 16'h045A, 16'h045C, 16'h045B, 16'h045F,
        16'h00A0, 16'h040E, 16'h045E, 16'h0408, 16'h00A4, 16'h0490, 16'h00A6, 16'h00A7,
        16'h0401, 16'h00A9, 16'h0404, 16'h00AB, 16'h00AC, 16'h00AD, 16'h00AE, 16'h0407,
        16'h00B0, 16'h00B1, 16'h0406, 16'h0456, 16'h0491, 16'h00B5, 16'h00B6, 16'h00B7,
        16'h0451, 16'h2116, 16'h0454, 16'h00BB, 16'h0458, 16'h0405, 16'h0455, 16'h0457,
        16'h0410, 16'h0411, 16'h0412, 16'h0413, 16'h0414, 16'h0415, 16'h0416, 16'h0417,
        16'h0418, 16'h0419, 16'h041A, 16'h041B, 16'h041C, 16'h041D, 16'h041E, 16'h041F,
        16'h0420, 16'h0421, 16'h0422, 16'h0423, 16'h0424, 16'h0425, 16'h0426, 16'h0427,
        16'h0428, 16'h0429, 16'h042A, 16'h042B, 16'h042C, 16'h042D, 16'h042E, 16'h042F,
        16'h0430, 16'h0431, 16'h0432, 16'h0433, 16'h0434, 16'h0435, 16'h0436, 16'h0437,
        16'h0438, 16'h0439, 16'h043A, 16'h043B, 16'h043C, 16'h043D, 16'h043E, 16'h043F,
        16'h0440, 16'h0441, 16'h0442, 16'h0443, 16'h0444, 16'h0445, 16'h0446, 16'h0447,
        16'h0448, 16'h0449, 16'h044A, 16'h044B, 16'h044C, 16'h044D, 16'h044E, 16'h044F
    };

    // Table word for a RAM address {codepage, slot}
    function automatic t_codepoint table_word(input logic [TBL_AW-1:0] addr);
        t_codepoint w;
        case (addr[TBL_AW-1 -: 2])
            CP_1250: w = MAP_1250[addr[6:0]];
            CP_1251: w = MAP_1251[addr[6:0]];
            CP_1252: w = MAP_1252[addr[6:0]];
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/cp2u8_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cp2u8_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cp2u8_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/codepage_to_utf8_transcoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// codepage_to_utf8_transcoder
// Converts legacy single-byte text (Windows-1252/1250/1251) to UTF-8, one
// to three output bytes per input byte; passthrough mode copies bytes.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-----------------------
//   in      | in        | i_in_valid / o_in_stall    | i_in_byte
//   out     | out       | o_out_valid / i_out_stall  | o_out_byte, o_last_byte
//   cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_codepage_select
//
// A request passes through the table read stage, then the emit register,
// which sends one output byte per cycle while the output does not stall,
// as the output register is byte-wide. The next request is read from the
// table RAM while the previous one still emits.
// After reset the table RAM is loaded from the package tables, the first
// three codepages; o_in_stall stays high meanwhile. Output stall holds the
// emit register and backs up into the read stage and the input.
// ----------------------------------------------------------------------------
module codepage_to_utf8_transcoder (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cp2u8_pkg::t_byte   i_in_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cp2u8_pkg::t_byte   o_out_byte,
    output logic               o_last_byte,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  cp2u8_pkg::t_codepage i_cfg_codepage_select
);
    import cp2u8_pkg::*;

    // configuration
    t_codepage          r_cp;

    // table load
    logic               r_filling;
    logic [TBL_AW-1:0]  r_fill_addr;

    // read stage
    logic               r_a_valid;
    logic               r_a_pass;
    t_byte              r_a_byte;

    // emit stage
    logic               r_b_valid;
    logic [1:0]         r_b_cnt;
    t_byte              r_b_byte0;
    t_byte              r_b_byte1;
    t_byte              r_b_byte2;

    logic               in_fire;
    logic               out_fire;
    logic               b_free;
    logic               b_load;
    logic               a_free;
    t_codepoint         ram_rdata;
    t_codepoint         code;
    logic [1:0]         n_cnt;
    t_byte              n_byte0;
    t_byte              n_byte1;
    t_byte              n_byte2;

    assign o_cfg_ready = 1'b1;

    assign out_fire   = r_b_valid & ~i_out_stall;
    assign b_free     = ~r_b_valid | (out_fire & (r_b_cnt == 2'd1));
    assign b_load     = r_a_valid & b_free;
    assign a_free     = ~r_a_valid | b_load;
    assign o_in_stall = r_filling | ~a_free;
    assign in_fire    = i_in_valid & ~o_in_stall;

    cp2u8_ram #(
        .WIDTH(TBL_WIDTH),
        .DEPTH(TBL_DEPTH)
    ) u_tbl_ram (
        .i_clk   (i_clk),
        .i_we    (r_filling),
        .i_waddr (r_fill_addr),
        .i_wdata (table_word(r_fill_addr)),
        .i_re    (in_fire),
        .i_raddr ({r_cp, i_in_byte[6:0]}),
        .o_rdata (ram_rdata)
    );

    // encode the looked-up code point (zero becomes U+FFFD), or pass the byte through
    always_comb begin
        code    = (ram_rdata == '0) ? CP_REPLACEMENT : ram_rdata;
        n_byte2 = '0;
        if (r_a_pass) begin
            n_cnt   = 2'd1;
            n_byte0 = r_a_byte;
            n_byte1 = '0;
        end else if (code < CP_TWO_LIMIT) begin
            n_cnt   = 2'd2;
            n_byte0 = {LEAD2_TAG, code[10:6]};
            n_byte1 = {CONT_TAG, code[5:0]};
        end else begin
            n_cnt   = 2'd3;
            n_byte0 = {LEAD3_TAG, code[15:12]};
            n_byte1 = {CONT_TAG, code[11:6]};
            n_byte2 = {CONT_TAG, code[5:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cp        <= CP_1252;
            r_filling   <= 1'b1;
            r_fill_addr <= '0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_b_cnt     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_cp <= i_cfg_codepage_select;
            end

            if (r_filling) begin
                r_fill_addr <= r_fill_addr + 1'b1;
                if (r_fill_addr == TBL_FILL_LAST) begin
                    r_filling <= 1'b0;
                end
            end

            if (a_free) begin
                r_a_valid <= in_fire;
            end

            // load a new item, advance within the current one, or drop it
            if (b_load) begin
                r_b_valid <= 1'b1;
                r_b_cnt   <= n_cnt;
            end else if (out_fire) begin
                r_b_cnt <= r_b_cnt - 1'b1;
                if (r_b_cnt == 2'd1) begin
                    r_b_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_a_byte <= i_in_byte;
            r_a_pass <= (r_cp == CP_PASS) | ~i_in_byte[7];
        end
        if (b_load) begin
            r_b_byte0 <= n_byte0;
            r_b_byte1 <= n_byte1;
            r_b_byte2 <= n_byte2;
        end else if (out_fire) begin
            r_b_byte0 <= r_b_byte1;
            r_b_byte1 <= r_b_byte2;
        end
    end

    assign o_out_valid = r_b_valid;
    assign o_out_byte  = r_b_byte0;
    assign o_last_byte = (r_b_cnt == 2'd1);

endmodule
